FILE: design/scir_pkg.sv
package scir_pkg;

  // Default coordinate width, Q16.16 at 32 bits
  localparam int DEF_COORD_WIDTH = 32;

  // Multiplier digit width: one partial product row per pipeline stage
  localparam int MUL_DIGIT = 8;

endpackage

FILE: design/scir_dly.sv
module scir_dly #(
  parameter int WD = 8,
  parameter int N  = 1
) (
  input  logic          clk,
  input  logic [WD-1:0] din,
  output logic [WD-1:0] dout
);

  logic [WD-1:0] tap_r [N];

  // Shift the payload one tap per cycle
  always_ff @(posedge clk) begin
    tap_r[0] <= din;
    for (int k = 1; k < N; k++) begin
      tap_r[k] <= tap_r[k-1];
    end
  end

  assign dout = tap_r[N-1];

endmodule

FILE: design/scir_mul.sv
module scir_mul #(
  parameter int AW = 34,
  parameter int BW = 34,
  parameter int DW = scir_pkg::MUL_DIGIT
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  localparam int NS = (BW + DW - 1) / DW;
  localparam int BP = NS * DW;
  localparam int QW = AW + BP;

  logic signed [AW-1:0] a_p   [NS-1];
  logic signed [BP-1:0] bp_p  [NS-1];
  logic signed [QW-1:0] acc_p [NS];
  logic signed [BP-1:0] b_pad;

  assign b_pad = BP'(b);

  // One digit of b per stage, top digit carries the sign
  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic signed [AW-1:0] a_in;
    logic signed [BP-1:0] b_in;
    logic signed [QW-1:0] acc_in;
    logic [DW-1:0]        dig;
    logic signed [DW:0]   dig_s;
    logic signed [AW+DW:0] prod;
    logic signed [QW-1:0] acc_nxt;

    if (k == 0) begin : g_first
      assign a_in   = a;
      assign b_in   = b_pad;
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_p[k-1];
      assign b_in   = bp_p[k-1];
      assign acc_in = acc_p[k-1];
    end

    always_comb begin
      dig     = b_in[k*DW +: DW];
      dig_s   = (k == NS - 1) ? $signed({dig[DW-1], dig}) : $signed({1'b0, dig});
      prod    = a_in * dig_s;
      acc_nxt = acc_in + (QW'(prod) <<< (k * DW));
    end

    always_ff @(posedge clk) begin
      acc_p[k] <= acc_nxt;
    end

    if (k < NS - 1) begin : g_pass
      always_ff @(posedge clk) begin
        a_p[k]  <= a_in;
        bp_p[k] <= b_in;
      end
    end
  end

  assign p = acc_p[NS-1][AW+BW-1:0];

endmodule

FILE: design/scir_sqrt.sv
module scir_sqrt #(
  parameter int NW = 132
) (
  input  logic               clk,
  input  logic [NW-1:0]      n,
  output logic [NW/2-1:0]    root
);

  localparam int RW  = NW / 2;
  localparam int RMW = RW + 3;

  logic [NW-1:0]  n_p    [RW-1];
  logic [RMW-1:0] rem_p  [RW-1];
  logic [RW-1:0]  root_p [RW];

  // One root bit per stage, two radicand bits brought down each time
  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [NW-1:0]  n_in;
    logic [RMW-1:0] rem_in;
    logic [RW-1:0]  root_in;
    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] trial;
    logic [RMW-1:0] rem_nxt;
    logic [RW-1:0]  root_nxt;

    if (k == 0) begin : g_first
      assign n_in    = n;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign n_in    = n_p[k-1];
      assign rem_in  = rem_p[k-1];
      assign root_in = root_p[k-1];
    end

    always_comb begin
      rem_sh = {rem_in[RMW-3:0], n_in[NW-1:NW-2]};
      trial  = RMW'({root_in, 2'b01});
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_in[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_in[RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      root_p[k] <= root_nxt;
    end

    if (k < RW - 1) begin : g_pass
      always_ff @(posedge clk) begin
        n_p[k]   <= n_in << 2;
        rem_p[k] <= rem_nxt;
      end
    end
  end

  assign root = root_p[RW-1];

endmodule

FILE: design/scir_div.sv
module scir_div #(
  parameter int NW  = 100,
  parameter int DRW = 68,
  parameter int QB  = 33
) (
  input  logic                 clk,
  input  logic signed [NW-1:0] num,
  input  logic [DRW-1:0]       den,
  output logic signed [QB:0]   quo,
  output logic                 ovf
);

  localparam int XW = NW + DRW + QB;
  localparam int CW = DRW + QB;

  logic [NW-1:0]  mag;
  logic           ovf_nxt;
  logic [CW-1:0]  rem0_r;
  logic [DRW-1:0] den0_r;
  logic           neg0_r;
  logic           ovf0_r;

  logic [CW-1:0]  rem_p [QB-1];
  logic [DRW-1:0] den_p [QB-1];
  logic [QB-1:0]  q_p   [QB];
  logic           neg_p [QB];
  logic           ovf_p [QB];

  logic signed [QB:0] quo_r;
  logic               ovf_r;

  // Take magnitude and flag quotients too large for the result width
  always_comb begin
    mag     = num[NW-1] ? NW'(-num) : NW'(num);
    ovf_nxt = XW'(mag) >= XW'({den, {QB{1'b0}}});
  end

  always_ff @(posedge clk) begin
    rem0_r <= ovf_nxt ? '0 : CW'(mag);
    den0_r <= den;
    neg0_r <= num[NW-1];
    ovf0_r <= ovf_nxt;
  end

  // Restoring division, one quotient bit per stage from the top
  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [CW-1:0]  rem_in;
    logic [DRW-1:0] den_in;
    logic [QB-1:0]  q_in;
    logic           neg_in;
    logic           ovf_in;
    logic [CW-1:0]  dsh;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_in = rem0_r;
      assign den_in = den0_r;
      assign q_in   = '0;
      assign neg_in = neg0_r;
      assign ovf_in = ovf0_r;
    end else begin : g_next
      assign rem_in = rem_p[k-1];
      assign den_in = den_p[k-1];
      assign q_in   = q_p[k-1];
      assign neg_in = neg_p[k-1];
      assign ovf_in = ovf_p[k-1];
    end

    always_comb begin
      dsh = CW'(den_in) << (QB - 1 - k);
      ge  = rem_in >= dsh;
    end

    always_ff @(posedge clk) begin
      q_p[k]   <= q_in | (QB'(ge) << (QB - 1 - k));
      neg_p[k] <= neg_in;
      ovf_p[k] <= ovf_in;
    end

    if (k < QB - 1) begin : g_pass
      always_ff @(posedge clk) begin
        rem_p[k] <= ge ? rem_in - dsh : rem_in;
        den_p[k] <= den_in;
      end
    end
  end

  // Apply the sign, truncating toward zero
  always_ff @(posedge clk) begin
    quo_r <= neg_p[QB-1] ? -$signed({1'b0, q_p[QB-1]}) : $signed({1'b0, q_p[QB-1]});
    ovf_r <= ovf_p[QB-1];
  end

  assign quo = quo_r;
  assign ovf = ovf_r;

endmodule

FILE: design/segment_circle_intersection.sv
// Segment against circle intersection, signed fixed point.
// Command channel: present a circle (center, radius) and a segment (start,
// end) on the in_ ports and raise start. busy is always low, so a
// transaction is taken on every cycle that start is high.
// Result channel: out_strobe is high for one cycle with both candidate
// points. A point whose valid bit is low shows zero coordinates. The
// receiver cannot hold results off and needs none: one result leaves per
// cycle, in order.
// Throughput: one transaction per cycle, every cycle.
// Results pass through the square root pipeline (one root bit per stage,
// 2W+2 stages), the four dividers (W+1 quotient bits, one per stage, plus
// two) and the digit-serial multiplier stages (one 8-bit digit per stage).
// Reset clears the valid chain and the result valid flags only; work in
// flight is dropped and no strobe leaves for it. There is no configuration.
module segment_circle_intersection #(
  parameter int COORD_WIDTH = scir_pkg::DEF_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_center_y,
  input  logic [COORD_WIDTH-2:0]        in_radius,
  input  logic signed [COORD_WIDTH-1:0] in_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_end_y,
  output logic                          out_strobe,
  output logic                          out_first_valid,
  output logic signed [COORD_WIDTH-1:0] out_first_x,
  output logic signed [COORD_WIDTH-1:0] out_first_y,
  output logic                          out_second_valid,
  output logic signed [COORD_WIDTH-1:0] out_second_x,
  output logic signed [COORD_WIDTH-1:0] out_second_y
);

  localparam int W    = COORD_WIDTH;
  localparam int DW   = scir_pkg::MUL_DIGIT;
  localparam int OW   = W + 1;
  localparam int XW   = W + 2;
  localparam int G1   = XW;
  localparam int L1   = (G1 + DW - 1) / DW;
  localparam int P1   = 2 * G1;
  localparam int G2   = P1;
  localparam int L2   = (G2 + DW - 1) / DW;
  localparam int P2   = 2 * G2;
  localparam int SNW  = 4 * W + 4;
  localparam int SRW  = SNW / 2;
  localparam int LS   = SRW;
  localparam int G3A  = SRW + 1;
  localparam int L3   = (XW + DW - 1) / DW;
  localparam int P3   = G3A + XW;
  localparam int NUMW = 3 * W + 4;
  localparam int QB   = W + 1;
  localparam int LD   = QB + 2;
  localparam int T1   = 1;
  localparam int T2   = T1 + 1;
  localparam int T3   = T2 + L1 + 1;
  localparam int T4   = T3 + L2 + 1;
  localparam int T5   = T4 + LS + L3 + 1;
  localparam int T6   = T5 + LD + 1;
  localparam int RW3  = W + 3;

  assign busy = 1'b0;

  // ---------------- stage 1: move to center, bounding box
  logic signed [OW-1:0] o1x_r, o1y_r, o2x_r, o2y_r;
  logic signed [W-1:0]  cx1_r, cy1_r, lx1_r, hx1_r, ly1_r, hy1_r;
  logic [W-2:0]         r1_r;
  logic [T6-1:0]        vld_r;

  always_ff @(posedge clk) begin
    o1x_r <= OW'(in_start_x) - OW'(in_center_x);
    o1y_r <= OW'(in_start_y) - OW'(in_center_y);
    o2x_r <= OW'(in_end_x) - OW'(in_center_x);
    o2y_r <= OW'(in_end_y) - OW'(in_center_y);
    cx1_r <= in_center_x;
    cy1_r <= in_center_y;
    r1_r  <= in_radius;
    lx1_r <= (in_start_x <= in_end_x) ? in_start_x : in_end_x;
    hx1_r <= (in_start_x <= in_end_x) ? in_end_x : in_start_x;
    ly1_r <= (in_start_y <= in_end_y) ? in_start_y : in_end_y;
    hy1_r <= (in_start_y <= in_end_y) ? in_end_y : in_start_y;
  end

  // Advance the valid chain alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[T6-2:0], start};
    end
  end

  // ---------------- stage 2: direction
  logic signed [XW-1:0] dx2_r, dy2_r;
  logic signed [OW-1:0] o1x2_r, o1y2_r, o2x2_r, o2y2_r;
  logic [W-2:0]         r2_r;

  always_ff @(posedge clk) begin
    dx2_r  <= XW'(o2x_r) - XW'(o1x_r);
    dy2_r  <= XW'(o2y_r) - XW'(o1y_r);
    o1x2_r <= o1x_r;
    o1y2_r <= o1y_r;
    o2x2_r <= o2x_r;
    o2y2_r <= o2y_r;
    r2_r   <= r1_r;
  end

  // ---------------- group 1 products
  logic signed [P1-1:0] dxdx, dydy, o1x_o2y, o1y_o2x, rr;

  scir_mul #(.AW(G1), .BW(G1), .DW(DW)) u_mul_dxdx (
    .clk(clk), .a(dx2_r), .b(dx2_r), .p(dxdx));
  scir_mul #(.AW(G1), .BW(G1), .DW(DW)) u_mul_dydy (
    .clk(clk), .a(dy2_r), .b(dy2_r), .p(dydy));
  scir_mul #(.AW(G1), .BW(G1), .DW(DW)) u_mul_c1 (
    .clk(clk), .a(G1'(o1x2_r)), .b(G1'(o2y2_r)), .p(o1x_o2y));
  scir_mul #(.AW(G1), .BW(G1), .DW(DW)) u_mul_c2 (
    .clk(clk), .a(G1'(o1y2_r)), .b(G1'(o2x2_r)), .p(o1y_o2x));
  scir_mul #(.AW(G1), .BW(G1), .DW(DW)) u_mul_rr (
    .clk(clk), .a(G1'($signed({1'b0, r2_r}))), .b(G1'($signed({1'b0, r2_r}))), .p(rr));

  logic [2*XW-1:0] dxy2_d;
  logic signed [XW-1:0] dx3, dy3;

  scir_dly #(.WD(2 * XW), .N(L1 + 1)) u_dly_dxy3 (
    .clk(clk), .din({dx2_r, dy2_r}), .dout(dxy2_d));
  assign dx3 = $signed(dxy2_d[2*XW-1:XW]);
  assign dy3 = $signed(dxy2_d[XW-1:0]);

  // ---------------- stage 3: squared length, cross product, r squared
  logic signed [P1-1:0] dr2_3_r, d3_r, rr3_r;

  always_ff @(posedge clk) begin
    dr2_3_r <= dxdx + dydy;
    d3_r    <= o1x_o2y - o1y_o2x;
    rr3_r   <= rr;
  end

  // ---------------- group 2 products
  logic signed [P2-1:0] rrdr2, dd, d_dy, d_dx;

  scir_mul #(.AW(G2), .BW(G2), .DW(DW)) u_mul_rrdr2 (
    .clk(clk), .a(rr3_r), .b(dr2_3_r), .p(rrdr2));
  scir_mul #(.AW(G2), .BW(G2), .DW(DW)) u_mul_dd (
    .clk(clk), .a(d3_r), .b(d3_r), .p(dd));
  scir_mul #(.AW(G2), .BW(G2), .DW(DW)) u_mul_ddy (
    .clk(clk), .a(d3_r), .b(G2'(dy3)), .p(d_dy));
  scir_mul #(.AW(G2), .BW(G2), .DW(DW)) u_mul_ddx (
    .clk(clk), .a(d3_r), .b(G2'(dx3)), .p(d_dx));

  logic [P1+2*XW-1:0] g2_side_d;
  logic [P1-1:0]      dr2_g2;
  logic signed [XW-1:0] dx4, dy4;

  scir_dly #(.WD(P1 + 2 * XW), .N(L2)) u_dly_g2 (
    .clk(clk), .din({dr2_3_r, dx3, dy3}), .dout(g2_side_d));
  assign dr2_g2 = g2_side_d[P1+2*XW-1:2*XW];
  assign dx4    = $signed(g2_side_d[2*XW-1:XW]);
  assign dy4    = $signed(g2_side_d[XW-1:0]);

  // ---------------- stage 4: discriminant, line terms, degenerate cases
  logic signed [P2-1:0]   diff, ty_w;
  logic [SNW-1:0]         disc4_r;
  logic                   bad4_r;
  logic signed [NUMW-1:0] tx4_r, ty4_r;
  logic signed [XW-1:0]   sdx4_r, ady4_r;
  logic [P1-1:0]          dr2_4_r;

  always_comb begin
    diff = rrdr2 - dd;
    ty_w = -d_dx;
  end

  always_ff @(posedge clk) begin
    disc4_r <= diff[SNW-1:0];
    bad4_r  <= (dr2_g2 == '0) || diff[P2-1];
    tx4_r   <= d_dy[NUMW-1:0];
    ty4_r   <= ty_w[NUMW-1:0];
    sdx4_r  <= dy4[XW-1] ? -dx4 : dx4;
    ady4_r  <= dy4[XW-1] ? -dy4 : dy4;
    dr2_4_r <= dr2_g2;
  end

  // ---------------- square root of the discriminant
  logic [SRW-1:0] sroot;

  scir_sqrt #(.NW(SNW)) u_sqrt (
    .clk(clk), .n(bad4_r ? '0 : disc4_r), .root(sroot));

  logic [2*XW-1:0]      sd_d;
  logic signed [XW-1:0] sdx_s, ady_s;

  scir_dly #(.WD(2 * XW), .N(LS)) u_dly_sd (
    .clk(clk), .din({sdx4_r, ady4_r}), .dout(sd_d));
  assign sdx_s = $signed(sd_d[2*XW-1:XW]);
  assign ady_s = $signed(sd_d[XW-1:0]);

  // ---------------- group 3 products
  logic signed [P3-1:0] ux, uy;

  scir_mul #(.AW(G3A), .BW(XW), .DW(DW)) u_mul_ux (
    .clk(clk), .a($signed({1'b0, sroot})), .b(sdx_s), .p(ux));
  scir_mul #(.AW(G3A), .BW(XW), .DW(DW)) u_mul_uy (
    .clk(clk), .a($signed({1'b0, sroot})), .b(ady_s), .p(uy));

  logic [2*NUMW+P1-1:0]   t_d;
  logic signed [NUMW-1:0] tx_d, ty_d;
  logic [P1-1:0]          dr2_d;

  scir_dly #(.WD(2 * NUMW + P1), .N(LS + L3)) u_dly_t (
    .clk(clk), .din({tx4_r, ty4_r, dr2_4_r}), .dout(t_d));
  assign tx_d  = $signed(t_d[2*NUMW+P1-1:NUMW+P1]);
  assign ty_d  = $signed(t_d[NUMW+P1-1:P1]);
  assign dr2_d = t_d[P1-1:0];

  // ---------------- stage 5: numerators
  logic signed [NUMW-1:0] n1x_r, n2x_r, n1y_r, n2y_r;
  logic [P1-1:0]          dr2_5_r;

  always_ff @(posedge clk) begin
    n1x_r   <= tx_d + ux[NUMW-1:0];
    n2x_r   <= tx_d - ux[NUMW-1:0];
    n1y_r   <= ty_d + uy[NUMW-1:0];
    n2y_r   <= ty_d - uy[NUMW-1:0];
    dr2_5_r <= dr2_d;
  end

  // ---------------- dividers
  logic signed [QB:0] q1x, q1y, q2x, q2y;
  logic               f1x, f1y, f2x, f2y;

  scir_div #(.NW(NUMW), .DRW(P1), .QB(QB)) u_div_1x (
    .clk(clk), .num(n1x_r), .den(dr2_5_r), .quo(q1x), .ovf(f1x));
  scir_div #(.NW(NUMW), .DRW(P1), .QB(QB)) u_div_1y (
    .clk(clk), .num(n1y_r), .den(dr2_5_r), .quo(q1y), .ovf(f1y));
  scir_div #(.NW(NUMW), .DRW(P1), .QB(QB)) u_div_2x (
    .clk(clk), .num(n2x_r), .den(dr2_5_r), .quo(q2x), .ovf(f2x));
  scir_div #(.NW(NUMW), .DRW(P1), .QB(QB)) u_div_2y (
    .clk(clk), .num(n2y_r), .den(dr2_5_r), .quo(q2y), .ovf(f2y));

  // Hold center and box until the quotients arrive
  logic [6*W-1:0]      side_d;
  logic signed [W-1:0] cxf, cyf, lxf, hxf, lyf, hyf;
  logic                badf;

  scir_dly #(.WD(6 * W), .N(T6 - 1 - T1)) u_dly_side (
    .clk(clk), .din({cx1_r, cy1_r, lx1_r, hx1_r, ly1_r, hy1_r}), .dout(side_d));
  scir_dly #(.WD(1), .N(T6 - 1 - T4)) u_dly_bad (
    .clk(clk), .din(bad4_r), .dout(badf));

  assign cxf = $signed(side_d[6*W-1:5*W]);
  assign cyf = $signed(side_d[5*W-1:4*W]);
  assign lxf = $signed(side_d[4*W-1:3*W]);
  assign hxf = $signed(side_d[3*W-1:2*W]);
  assign lyf = $signed(side_d[2*W-1:W]);
  assign hyf = $signed(side_d[W-1:0]);

  // ---------------- stage 6: add center back, box test, drive result
  logic signed [RW3-1:0] x1, y1, x2, y2;
  logic                  v1, v2;

  always_comb begin
    x1 = RW3'(q1x) + RW3'(cxf);
    y1 = RW3'(q1y) + RW3'(cyf);
    x2 = RW3'(q2x) + RW3'(cxf);
    y2 = RW3'(q2y) + RW3'(cyf);
    v1 = vld_r[T6-2] && !badf && !f1x && !f1y &&
         (x1 >= RW3'(lxf)) && (x1 <= RW3'(hxf)) &&
         (y1 >= RW3'(lyf)) && (y1 <= RW3'(hyf));
    v2 = vld_r[T6-2] && !badf && !f2x && !f2y &&
         (x2 >= RW3'(lxf)) && (x2 <= RW3'(hxf)) &&
         (y2 >= RW3'(lyf)) && (y2 <= RW3'(hyf));
  end

  logic                v1_r, v2_r;
  logic signed [W-1:0] x1_r, y1_r, x2_r, y2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1;
      v2_r <= v2;
    end
    x1_r <= v1 ? x1[W-1:0] : '0;
    y1_r <= v1 ? y1[W-1:0] : '0;
    x2_r <= v2 ? x2[W-1:0] : '0;
    y2_r <= v2 ? y2[W-1:0] : '0;
  end

  assign out_strobe       = vld_r[T6-1];
  assign out_first_valid  = v1_r;
  assign out_first_x      = x1_r;
  assign out_first_y      = y1_r;
  assign out_second_valid = v2_r;
  assign out_second_x     = x2_r;
  assign out_second_y     = y2_r;

endmodule

FILE: design/scir_chk.sv
module scir_chk #(
  parameter int COORD_WIDTH = scir_pkg::DEF_COORD_WIDTH
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          busy,
  input logic                          out_strobe,
  input logic                          out_first_valid,
  input logic signed [COORD_WIDTH-1:0] out_first_x,
  input logic signed [COORD_WIDTH-1:0] out_first_y,
  input logic                          out_second_valid,
  input logic signed [COORD_WIDTH-1:0] out_second_x,
  input logic signed [COORD_WIDTH-1:0] out_second_y
);

  // The block takes a transaction every cycle
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

  // Valid flags only appear with a strobe
  a_valid_needs_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    !out_strobe |-> !out_first_valid && !out_second_valid)
    else $error("valid flag without strobe");

  // A point whose valid flag is low shows zero coordinates
  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_first_valid |-> out_first_x == '0 && out_first_y == '0)
    else $error("first point not zeroed");

  a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_second_valid |-> out_second_x == '0 && out_second_y == '0)
    else $error("second point not zeroed");

  // No result comes out of a pipeline that was just reset
  a_no_strobe_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(rst_n))
    else $error("strobe right after reset");

endmodule

bind segment_circle_intersection scir_chk #(.COORD_WIDTH(COORD_WIDTH)) u_scir_chk (.*);
